// ===== src/tgc_pkg.sv =====
// tgc_pkg: shared types and constants for the touch gesture classifier.
// No dependencies; used by the interfaces, tgc_classify and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tgc_pkg;

	localparam int TRAVEL_BITS = 13;
	localparam int TICK_BITS   = 32;
	localparam int HOLD_BITS   = 16;
	localparam int COUNT_BITS  = 32;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 2;

	localparam logic [TRAVEL_BITS-1:0] TRAVEL_MAX = {TRAVEL_BITS{1'b1}};

	localparam logic [HOLD_BITS-1:0]   LONG_PRESS_RST = 16'd14;
	localparam logic [TRAVEL_BITS-1:0] MOVE_THR_RST   = 13'd12;
	localparam logic [TRAVEL_BITS-1:0] SWIPE_THR_RST  = 13'd60;

	typedef enum logic [2:0] {
		KIND_TAP   = 3'd0,
		KIND_LONG  = 3'd1,
		KIND_DRAG  = 3'd2,
		KIND_UP    = 3'd3,
		KIND_DOWN  = 3'd4,
		KIND_LEFT  = 3'd5,
		KIND_RIGHT = 3'd6
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOUCH_ENABLE = 2'd0,
		REG_LONG_PRESS   = 2'd1,
		REG_MOVE_THR     = 2'd2,
		REG_SWIPE_THR    = 2'd3
	} reg_idx_t;

	// thresholds handed to the classifier
	typedef struct packed {
		logic [HOLD_BITS-1:0]   long_press_ticks;
		logic [TRAVEL_BITS-1:0] move_thr;
		logic [TRAVEL_BITS-1:0] swipe_thr;
	} thr_t;

endpackage

`default_nettype wire

// ===== src/tgc_sample_if.sv =====
// tgc_sample_if: valid/ready channel carrying one pointer sample request.
// Depends on tgc_pkg for the tick width.
`timescale 1ns / 1ps
`default_nettype none

interface tgc_sample_if #(
	parameter int COORD_BITS = 12
);
	logic                          valid;
	logic                          ready;
	logic                          button_down;
	logic [COORD_BITS-1:0]         pointer_x;
	logic [COORD_BITS-1:0]         pointer_y;
	logic [tgc_pkg::TICK_BITS-1:0] tick_now;

	modport source (output valid, output button_down, output pointer_x,
		output pointer_y, output tick_now, input ready);
	modport sink (input valid, input button_down, input pointer_x,
		input pointer_y, input tick_now, output ready);
endinterface

`default_nettype wire

// ===== src/tgc_gesture_if.sv =====
// tgc_gesture_if: valid/ready channel carrying one classified gesture request.
// Depends on tgc_pkg for kind_t and the count width.
`timescale 1ns / 1ps
`default_nettype none

interface tgc_gesture_if #(
	parameter int COORD_BITS = 12
);
	logic                           valid;
	logic                           ready;
	tgc_pkg::kind_t                 gesture_kind;
	logic [COORD_BITS-1:0]          end_x;
	logic [COORD_BITS-1:0]          end_y;
	logic [tgc_pkg::COUNT_BITS-1:0] gesture_count;

	modport source (output valid, output gesture_kind, output end_x,
		output end_y, output gesture_count, input ready);
	modport sink (input valid, input gesture_kind, input end_x,
		input end_y, input gesture_count, output ready);
endinterface

`default_nettype wire

// ===== src/tgc_classify.sv =====
// tgc_classify: travel, peak update and gesture decision for one sample.
// Purely combinational; depends on tgc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgc_classify #(
	parameter int COORD_BITS = 12
) (
	input  wire logic [COORD_BITS-1:0]           px,
	input  wire logic [COORD_BITS-1:0]           py,
	input  wire logic [COORD_BITS-1:0]           start_x,
	input  wire logic [COORD_BITS-1:0]           start_y,
	input  wire logic [tgc_pkg::TRAVEL_BITS-1:0] peak,
	input  wire logic [tgc_pkg::TICK_BITS-1:0]   held,
	input  wire tgc_pkg::thr_t                   thr,
	output logic [tgc_pkg::TRAVEL_BITS-1:0]      peak_next,
	output tgc_pkg::kind_t                       kind
);
	localparam int SUM_W = COORD_BITS + 1;
	localparam int CMP_W = (SUM_W > tgc_pkg::TRAVEL_BITS) ? SUM_W : tgc_pkg::TRAVEL_BITS;

	logic [COORD_BITS-1:0]           adx, ady;
	logic [SUM_W-1:0]                sum;
	logic [CMP_W-1:0]                sum_w;
	logic [tgc_pkg::TRAVEL_BITS-1:0] sum_sat;

	always_comb begin
		adx   = (px >= start_x) ? (px - start_x) : (start_x - px);
		ady   = (py >= start_y) ? (py - start_y) : (start_y - py);
		sum   = {1'b0, adx} + {1'b0, ady};
		sum_w = CMP_W'(sum);
		// peak register is 13 bits; clamp before the max
		if (sum_w > CMP_W'(tgc_pkg::TRAVEL_MAX))
			sum_sat = tgc_pkg::TRAVEL_MAX;
		else
			sum_sat = sum_w[tgc_pkg::TRAVEL_BITS-1:0];
		peak_next = (sum_sat > peak) ? sum_sat : peak;

		if (peak_next < thr.move_thr) begin
			if (held >= tgc_pkg::TICK_BITS'(thr.long_press_ticks))
				kind = tgc_pkg::KIND_LONG;
			else
				kind = tgc_pkg::KIND_TAP;
		end else if (sum_w >= CMP_W'(thr.swipe_thr)) begin
			// horizontal wins an axis tie
			if (adx >= ady)
				kind = (px > start_x) ? tgc_pkg::KIND_RIGHT : tgc_pkg::KIND_LEFT;
			else
				kind = (py > start_y) ? tgc_pkg::KIND_DOWN : tgc_pkg::KIND_UP;
		end else begin
			kind = tgc_pkg::KIND_DRAG;
		end
	end
endmodule

`default_nettype wire

// ===== src/touch_gesture_classifier.sv =====
// touch_gesture_classifier: top level, press tracking and result register.
// Depends on tgc_pkg, tgc_sample_if, tgc_gesture_if and tgc_classify.
//
// Usage:
//   samples  - sink channel; one request per pointer sample (button level,
//              x, y, tick). Accepted when valid and ready are both high.
//   gestures - source channel; one request per recognized gesture, issued
//              only for a release that ends a tracked press.
//   cfg_*    - write port: cfg_we, cfg_index (register number), cfg_data.
//              Write only while the block is idle.
// Timing: a sample is captured into the _s1 input register; once the result
//   slot is free or being read, the classifier compares it against the press
//   state and loads the result register. Throughput is one sample per cycle
//   while no gesture waits unread, set by the single pass through the classifier
//   between the _s1 register and the result register.
// Stall: while a gesture waits unread, the _s1 stage holds; samples are still
//   taken as long as _s1 is free, so at most one sample queues behind it.
// Reset: press state, peak travel and gesture count go to zero, recognition
//   is disabled, thresholds return to 14 ticks, 12 and 60 pixels.
`timescale 1ns / 1ps
`default_nettype none

module touch_gesture_classifier #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	tgc_sample_if.sink                          samples,
	tgc_gesture_if.source                       gestures,
	input  wire logic                           cfg_we,
	input  wire logic [tgc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tgc_pkg::CFG_DATA_W-1:0] cfg_data
);

	// ---------------- configuration registers ----------------
	logic          enable_q;
	tgc_pkg::thr_t thr_q;

	// ---------------- press state ----------------
	logic                            press_active_q;
	logic [COORD_BITS-1:0]           start_x_q, start_y_q;
	logic [tgc_pkg::TICK_BITS-1:0]   start_tick_q;
	logic [tgc_pkg::TRAVEL_BITS-1:0] peak_q;
	logic [tgc_pkg::COUNT_BITS-1:0]  total_q;

	// ---------------- input stage ----------------
	logic                          valid_s1;
	logic                          down_s1;
	logic [COORD_BITS-1:0]         x_s1, y_s1;
	logic [tgc_pkg::TICK_BITS-1:0] tick_s1;

	// ---------------- result register ----------------
	logic                           out_valid_q;
	tgc_pkg::kind_t                 kind_q;
	logic [COORD_BITS-1:0]          end_x_q, end_y_q;
	logic [tgc_pkg::COUNT_BITS-1:0] count_q;

	// ---------------- classifier ----------------
	logic [tgc_pkg::TRAVEL_BITS-1:0] peak_next;
	tgc_pkg::kind_t                  kind_next;
	logic [tgc_pkg::TICK_BITS-1:0]   held;

	// Stage control: the s1 sample is consumed when the result slot is free
	// or being emptied this cycle.
	logic advance, in_fire, work, press_start, press_track, release_fire;

	assign advance      = !out_valid_q || gestures.ready;
	assign in_fire      = samples.valid && samples.ready;
	assign work         = valid_s1 && advance && enable_q;
	assign press_start  = work && down_s1 && !press_active_q;
	assign press_track  = work && press_active_q;
	assign release_fire = press_track && !down_s1;

	assign samples.ready = !valid_s1 || advance;

	// held time wraps with the tick counter
	assign held = tick_s1 - start_tick_q;

	tgc_classify #(
		.COORD_BITS(COORD_BITS)
	) u_classify (
		.px       (x_s1),
		.py       (y_s1),
		.start_x  (start_x_q),
		.start_y  (start_y_q),
		.peak     (peak_q),
		.held     (held),
		.thr      (thr_q),
		.peak_next(peak_next),
		.kind     (kind_next)
	);

	// Input register: control reset, payload free-running.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			down_s1 <= samples.button_down;
			x_s1    <= samples.pointer_x;
			y_s1    <= samples.pointer_y;
			tick_s1 <= samples.tick_now;
		end
	end

	// Configuration and press state. Config writes must only come while idle, so
	// that they never collide with a sample being processed; the block does not
	// enforce this. Clearing the enable drops any press in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q             <= 1'b0;
			thr_q.long_press_ticks <= tgc_pkg::LONG_PRESS_RST;
			thr_q.move_thr         <= tgc_pkg::MOVE_THR_RST;
			thr_q.swipe_thr        <= tgc_pkg::SWIPE_THR_RST;
			press_active_q       <= 1'b0;
			start_x_q            <= '0;
			start_y_q            <= '0;
			start_tick_q         <= '0;
			peak_q               <= '0;
			total_q              <= '0;
		end else begin
			if (press_start) begin
				press_active_q <= 1'b1;
				start_x_q      <= x_s1;
				start_y_q      <= y_s1;
				start_tick_q   <= tick_s1;
				peak_q         <= '0;
			end else if (press_track) begin
				peak_q <= peak_next;
				if (!down_s1) begin
					press_active_q <= 1'b0;
					total_q        <= total_q + tgc_pkg::COUNT_BITS'(1);
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					tgc_pkg::REG_TOUCH_ENABLE: begin
						enable_q <= cfg_data[0];
						if (!cfg_data[0])
							press_active_q <= 1'b0;
					end
					tgc_pkg::REG_LONG_PRESS: begin
						thr_q.long_press_ticks <= cfg_data[tgc_pkg::HOLD_BITS-1:0];
					end
					tgc_pkg::REG_MOVE_THR: begin
						thr_q.move_thr <= cfg_data[tgc_pkg::TRAVEL_BITS-1:0];
					end
					tgc_pkg::REG_SWIPE_THR: begin
						thr_q.swipe_thr <= cfg_data[tgc_pkg::TRAVEL_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= release_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (release_fire) begin
			kind_q  <= kind_next;
			end_x_q <= x_s1;
			end_y_q <= y_s1;
			count_q <= total_q + tgc_pkg::COUNT_BITS'(1);
		end
	end

	assign gestures.valid         = out_valid_q;
	assign gestures.gesture_kind  = kind_q;
	assign gestures.end_x         = end_x_q;
	assign gestures.end_y         = end_y_q;
	assign gestures.gesture_count = count_q;

	// ---------------- assertions ----------------
	// The shown count always matches the running gesture total.
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (count_q == total_q))
		else $error("gesture count does not match running total");

	// With recognition off no press can be tracked.
	a_no_press_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		!enable_q |-> !press_active_q)
		else $error("press tracked while disabled");

	// A sample in s1 that cannot advance stays put.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(x_s1) && $stable(down_s1)))
		else $error("s1 sample lost under stall");

	// A release always clears the press and emits a result next cycle.
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		release_fire && !cfg_we |=> (out_valid_q && !press_active_q))
		else $error("release did not produce a gesture");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: self-checking bench for touch_gesture_classifier, with a small gesture scoreboard.
// Depends on tgc_pkg, tgc_sample_if, tgc_gesture_if and the block itself.
`timescale 1ns / 1ps

typedef logic [11:0] coord_t;

typedef struct {
	tgc_pkg::kind_t kind;
	coord_t         ex;
	coord_t         ey;
	logic [31:0]    count;
} exp_gesture_t;

// Scoreboard: tracks the press state and the thresholds, predicts the gesture
// each accepted sample causes, and compares gestures as they come out.
class gesture_board;
	bit                                   enabled;
	logic [tgc_pkg::HOLD_BITS-1:0]        long_ticks;
	logic [tgc_pkg::TRAVEL_BITS-1:0]      move_thr;
	logic [tgc_pkg::TRAVEL_BITS-1:0]      swipe_thr;
	bit                                   tracking;
	coord_t                               sx;
	coord_t                               sy;
	logic [31:0]                          st;
	logic [tgc_pkg::TRAVEL_BITS-1:0]      peak;
	logic [31:0]                          total;
	exp_gesture_t                         expected[$];
	int                                   errors;

	function new();
		enabled    = 1'b0;
		long_ticks = tgc_pkg::LONG_PRESS_RST;
		move_thr   = tgc_pkg::MOVE_THR_RST;
		swipe_thr  = tgc_pkg::SWIPE_THR_RST;
		tracking   = 1'b0;
		sx         = '0;
		sy         = '0;
		st         = '0;
		peak       = '0;
		total      = '0;
		errors     = 0;
	endfunction

	function void apply_reg(tgc_pkg::reg_idx_t idx, logic [tgc_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			tgc_pkg::REG_TOUCH_ENABLE: begin
				enabled = data[0];
				if (!enabled)
					tracking = 1'b0;
			end
			tgc_pkg::REG_LONG_PRESS: long_ticks = data;
			tgc_pkg::REG_MOVE_THR:   move_thr = data[12:0];
			tgc_pkg::REG_SWIPE_THR:  swipe_thr = data[12:0];
			default: ;
		endcase
	endfunction

	function void note_sample(bit down, coord_t x, coord_t y, logic [31:0] tick);
		logic [12:0]  adx;
		logic [12:0]  ady;
		logic [13:0]  travel;
		logic [12:0]  sat;
		logic [31:0]  held;
		exp_gesture_t g;
		if (!enabled)
			return;
		if (down && !tracking) begin
			tracking = 1'b1;
			sx       = x;
			sy       = y;
			st       = tick;
			peak     = '0;
			return;
		end
		if (!tracking)
			return;
		adx    = (x >= sx) ? 13'(x - sx) : 13'(sx - x);
		ady    = (y >= sy) ? 13'(y - sy) : 13'(sy - y);
		travel = adx + ady;
		sat    = (travel > 14'(tgc_pkg::TRAVEL_MAX)) ? tgc_pkg::TRAVEL_MAX : travel[12:0];
		if (sat > peak)
			peak = sat;
		if (down)
			return;
		tracking = 1'b0;
		held     = tick - st;
		if (peak < move_thr) begin
			g.kind = (held >= {16'd0, long_ticks}) ? tgc_pkg::KIND_LONG : tgc_pkg::KIND_TAP;
		end else if (travel >= 14'(swipe_thr)) begin
			// ties between the axes go to the horizontal swipe
			if (adx >= ady)
				g.kind = (x > sx) ? tgc_pkg::KIND_RIGHT : tgc_pkg::KIND_LEFT;
			else
				g.kind = (y > sy) ? tgc_pkg::KIND_DOWN : tgc_pkg::KIND_UP;
		end else begin
			g.kind = tgc_pkg::KIND_DRAG;
		end
		total   = total + 1;
		g.ex    = x;
		g.ey    = y;
		g.count = total;
		expected.push_back(g);
	endfunction

	function void check_gesture(tgc_pkg::kind_t kind, coord_t x, coord_t y, logic [31:0] count);
		exp_gesture_t g;
		if (expected.size() == 0) begin
			$error("unexpected gesture: kind %0d end (%0d,%0d) count %0d", kind, x, y, count);
			errors++;
			return;
		end
		g = expected.pop_front();
		if (kind !== g.kind) begin
			$error("gesture_kind: expected %0d, got %0d", g.kind, kind);
			errors++;
		end
		if (x !== g.ex) begin
			$error("end_x: expected %0d, got %0d", g.ex, x);
			errors++;
		end
		if (y !== g.ey) begin
			$error("end_y: expected %0d, got %0d", g.ey, y);
			errors++;
		end
		if (count !== g.count) begin
			$error("gesture_count: expected %0d, got %0d", g.count, count);
			errors++;
		end
	endfunction

	function int pending();
		return expected.size();
	endfunction
endclass

module testbench;
	localparam int COORD_W    = 12;
	localparam int IDLE_LIMIT = 2000;  // cycles without any handshake before giving up
	localparam int SETTLE     = 8;     // margin for the pipeline to empty

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_we;
	logic [tgc_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [tgc_pkg::CFG_DATA_W-1:0]     cfg_data;

	tgc_sample_if  #(.COORD_BITS(COORD_W)) smp ();
	tgc_gesture_if #(.COORD_BITS(COORD_W)) gst ();

	touch_gesture_classifier #(.COORD_BITS(COORD_W)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (smp),
		.gestures (gst),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	gesture_board board = new();

	// sender burst/gap control and receiver stall pattern, changed per phase
	int burst_left = 0;
	bit gaps_on    = 1'b1;
	int rx_mode    = 0;
	int rx_run     = 0;
	int idle_cycles = 0;
	int items_sent  = 0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Monitor: every handshake is sampled on the edge, pre-edge values only.
	always @(posedge clk) begin
		if (arst_n && smp.valid && smp.ready)
			board.note_sample(smp.button_down, smp.pointer_x, smp.pointer_y, smp.tick_now);
		if (arst_n && gst.valid && gst.ready)
			board.check_gesture(gst.gesture_kind, gst.end_x, gst.end_y, gst.gesture_count);
	end

	// Receiver: mode 0 always ready, mode 1 short random stalls, mode 2 long runs.
	always @(posedge clk) begin
		if (rx_run == 0) begin
			case (rx_mode)
				0: begin
					gst.ready <= 1'b1;
					rx_run = $urandom_range(1, 50);
				end
				1: begin
					gst.ready <= ($urandom_range(0, 3) != 0);
					rx_run = 0;
				end
				default: begin
					gst.ready <= 1'($urandom_range(0, 1));
					rx_run = $urandom_range(1, 40);
				end
			endcase
		end else begin
			rx_run--;
		end
	end

	// Watchdog: only cycles with no handshake at all count toward the limit.
	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (gst.valid && gst.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	function automatic int jitter(int c, int r);
		return c + int'($urandom_range(0, 2 * r)) - r;
	endfunction

	// Tick advance between samples: mostly small, now and then a huge jump.
	function automatic logic [31:0] tick_step();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return $urandom;
		else if (r < 4)
			return $urandom_range(0, 30);
		else
			return $urandom_range(0, 6);
	endfunction

	// Drive one sample request and wait for it to be taken. Leaves valid high;
	// the next call or drain() decides what happens to it. Called on an edge.
	task automatic push_sample(input bit down, input int x, input int y, input logic [31:0] tick);
		int cx;
		int cy;
		cx = (x < 0) ? 0 : ((x > 4095) ? 4095 : x);
		cy = (y < 0) ? 0 : ((y > 4095) ? 4095 : y);
		if (burst_left == 0) begin
			if (gaps_on) begin
				smp.valid <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		smp.valid       <= 1'b1;
		smp.button_down <= down;
		smp.pointer_x   <= coord_t'(cx);
		smp.pointer_y   <= coord_t'(cy);
		smp.tick_now    <= tick;
		do
			@(posedge clk);
		while (!smp.ready);
		burst_left--;
		items_sent++;
	endtask

	// Lower valid, let the monitor see the last request, wait for every
	// predicted gesture, then give the pipeline time to empty.
	task automatic drain();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input tgc_pkg::reg_idx_t idx, input logic [tgc_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.apply_reg(idx, data);
		@(posedge clk);
	endtask

	// Bits above the enable, move and swipe fields are junk on purpose; the block must ignore them.
	task automatic set_config(input bit en, input logic [15:0] lp, input logic [12:0] mv,
		input logic [12:0] sw);
		write_reg(tgc_pkg::REG_TOUCH_ENABLE, {15'($urandom), en});
		write_reg(tgc_pkg::REG_LONG_PRESS, lp);
		write_reg(tgc_pkg::REG_MOVE_THR, {3'($urandom), mv});
		write_reg(tgc_pkg::REG_SWIPE_THR, {3'($urandom), sw});
	endtask

	// One press: down, zero to four held samples, release. Mode picks the motion.
	task automatic play_gesture();
		int          sx;
		int          sy;
		int          ex;
		int          ey;
		int          nh;
		int          mode;
		int          mag;
		logic [31:0] t;
		sx   = $urandom_range(0, 4095);
		sy   = $urandom_range(0, 4095);
		t    = $urandom;
		mode = $urandom_range(0, 3);
		nh   = $urandom_range(0, 4);
		ex   = sx;
		ey   = sy;
		if (mode == 1) begin
			mag = $urandom_range(0, 4095);
			if ($urandom_range(0, 1)) begin
				ex = $urandom_range(0, 1) ? sx + mag : sx - mag;
				ey = jitter(sy, $urandom_range(0, mag));
			end else begin
				ey = $urandom_range(0, 1) ? sy + mag : sy - mag;
				ex = jitter(sx, $urandom_range(0, mag));
			end
		end
		push_sample(1'b1, sx, sy, t);
		for (int k = 1; k <= nh; k++) begin
			t = t + tick_step();
			case (mode)
				0: push_sample(1'b1, jitter(sx, 6), jitter(sy, 6), t);
				1: push_sample(1'b1, sx + (ex - sx) * k / (nh + 1), sy + (ey - sy) * k / (nh + 1), t);
				2: push_sample(1'b1, jitter(sx, 300), jitter(sy, 300), t);
				default: push_sample(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095), t);
			endcase
		end
		t = t + tick_step();
		case (mode)
			0: push_sample(1'b0, jitter(sx, 6), jitter(sy, 6), t);
			1: push_sample(1'b0, ex, ey, t);
			2: push_sample(1'b0, jitter(sx, 20), jitter(sy, 20), t);
			default: push_sample(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095), t);
		endcase
	endtask

	task automatic run_random(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			// some stray samples: lone releases, repeated presses, random levels
			if ($urandom_range(0, 99) < 12)
				push_sample(1'($urandom_range(0, 1)), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom);
			else
				play_gesture();
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		smp.valid       = 1'b0;
		smp.button_down = 1'b0;
		smp.pointer_x   = '0;
		smp.pointer_y   = '0;
		smp.tick_now    = '0;
		gst.ready       = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Out of reset recognition is off: this press is ignored.
		rx_mode = 1;
		gaps_on = 1'b1;
		push_sample(1'b1, 10, 10, 32'd0);
		push_sample(1'b0, 10, 10, 32'd50);
		drain();
		set_config(1'b1, 16'd14, 13'd12, 13'd60);

		push_sample(1'b0, 10, 10, 32'd100);                  // release with no press
		push_sample(1'b1, 0, 0, 32'd0);                      // tap
		push_sample(1'b0, 0, 0, 32'd5);
		push_sample(1'b1, 4095, 4095, 32'hFFFF_FFF8);        // long press across tick wrap
		push_sample(1'b0, 4095, 4095, 32'd6);
		push_sample(1'b1, 100, 100, 32'd10);                 // swipe right
		push_sample(1'b0, 4095, 100, 32'd20);
		push_sample(1'b1, 4095, 0, 32'd30);                  // swipe left
		push_sample(1'b0, 0, 0, 32'd31);
		push_sample(1'b1, 0, 0, 32'd40);                     // swipe down
		push_sample(1'b0, 0, 4095, 32'd41);
		push_sample(1'b1, 0, 4095, 32'd50);                  // swipe up
		push_sample(1'b0, 0, 0, 32'd51);
		push_sample(1'b1, 500, 500, 32'd60);                 // drag: moved, net short
		push_sample(1'b1, 530, 500, 32'd61);
		push_sample(1'b0, 505, 500, 32'd62);
		push_sample(1'b1, 1000, 1000, 32'd70);               // equal axes go horizontal
		push_sample(1'b0, 1100, 1100, 32'd71);
		push_sample(1'b1, 200, 200, 32'd80);                 // far out and back: drag
		push_sample(1'b1, 2000, 3000, 32'd81);
		push_sample(1'b0, 200, 200, 32'd82);

		// press abandoned by disabling; the later release finds no press
		push_sample(1'b1, 300, 300, 32'd90);
		drain();
		write_reg(tgc_pkg::REG_TOUCH_ENABLE, 16'd0);
		write_reg(tgc_pkg::REG_TOUCH_ENABLE, 16'd1);
		push_sample(1'b0, 300, 300, 32'd95);
		drain();

		// zero thresholds: a still press is moving, zero net travel is swipe left
		set_config(1'b1, 16'd0, 13'd0, 13'd0);
		push_sample(1'b1, 7, 7, 32'd0);
		push_sample(1'b0, 7, 7, 32'd0);
		push_sample(1'b1, 40, 40, 32'd3);
		push_sample(1'b1, 90, 60, 32'd4);
		push_sample(1'b0, 40, 40, 32'd5);
		drain();

		// Random part, one threshold setting per phase.
		for (int p = 0; p < 10; p++) begin
			rx_mode = p % 3;
			gaps_on = (p % 2) == 0;
			case (p)
				0: set_config(1'b1, 16'd14, 13'd12, 13'd60);
				1: set_config(1'b1, 16'd0, 13'd0, 13'd0);
				2: set_config(1'b1, 16'hFFFF, 13'h1FFF, 13'h1FFF);
				3: set_config(1'b0, 16'($urandom), 13'($urandom), 13'($urandom));
				4: set_config(1'b1, 16'd1, 13'd1, 13'd1);
				default: set_config(1'b1, 16'($urandom_range(0, 40)), 13'($urandom_range(0, 64)),
					13'($urandom_range(0, 700)));
			endcase
			// recognition off in phase 3: everything there is ignored
			run_random((p == 3) ? 40 : ((p == 1 || p == 2) ? 150 : 200));
			drain();
		end

		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== files.f =====
src/tgc_pkg.sv
src/tgc_sample_if.sv
src/tgc_gesture_if.sv
src/tgc_classify.sv
src/touch_gesture_classifier.sv
tb/testbench.sv
